### hw/rtl/lpud_pkg.sv
// Shared types and constants of the length-prefixed unit deframer.
package lpud_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    StPayload = 2'd0,
    StEmpty   = 2'd1,
    StOverrun = 2'd2
  } status_e;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned KindBits  = 3;
  localparam int unsigned TimeBits  = 47;
  localparam int unsigned RtpBits   = 32;
  localparam int unsigned ModeBits  = 3;
  localparam int unsigned LenBits   = 32;
  localparam int unsigned MaxPrefix = 4;

  // ceil(t * 90 / 1000) = floor((t * 9 + 99) / 100)
  localparam int unsigned TimeMul   = 9;
  localparam int unsigned RoundAdd  = 99;
  localparam int unsigned DivBase   = 100;
  // floor(x / 100) = (x * DivRecip) >> DivShift for x below 100 * 256
  localparam int unsigned DivRecip  = 41944;
  localparam int unsigned DivShift  = 22;
  localparam int unsigned RemBits   = 7;
  localparam int unsigned XBits     = RemBits + ByteBits;
  localparam int unsigned RecipBits = 16;
  localparam int unsigned NDigits   = 7;
  localparam int unsigned WBits     = NDigits * ByteBits;

  // Work record passed from the front to the back
  typedef struct packed {
    logic                  start;
    logic                  emit;
    logic [KindBits-1:0]   kind;
    logic [TimeBits-1:0]   time_us;
    logic [ByteBits-1:0]   data;
    status_e               status;
    logic                  first;
    logic                  last;
  } rec_t;

endpackage

### hw/rtl/lpud_fifo.sv
// Short flop queue of work records between the front and the back.
module lpud_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  lpud_pkg::rec_t wr_data_i,
  input  logic           rd_en_i,
  output lpud_pkg::rec_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lpud_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the written beat
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/lpud_front.sv
// Front end: walks the frame byte by byte, parses prefixes and classifies each byte.
module lpud_front #(
  parameter int unsigned FrameLenBits = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [lpud_pkg::ModeBits-1:0]    prefix_mode_i,
  input  logic [lpud_pkg::ByteBits-1:0]    data_byte_i,
  input  logic                             frame_start_i,
  input  logic [23:0]                      frame_bytes_i,
  input  logic [lpud_pkg::KindBits-1:0]    frame_kind_i,
  input  logic [lpud_pkg::TimeBits-1:0]    time_us_i,
  output logic                             rec_push_o,
  output lpud_pkg::rec_t                   rec_o
);

  localparam int unsigned LenW = lpud_pkg::LenBits;

  logic                              in_prefix_q, in_prefix_d;
  logic [2:0]                        prefix_count_q, prefix_count_d;
  logic [LenW-1:0]                   length_accum_q, length_accum_d;
  logic [LenW-1:0]                   unit_remaining_q, unit_remaining_d;
  logic [FrameLenBits-1:0]           frame_remaining_q, frame_remaining_d;
  logic                              discarding_q, discarding_d;

  logic [FrameLenBits-1:0]           frame_cur;
  logic [FrameLenBits-1:0]           frame_after;
  logic [2:0]                        cap;
  logic                              emit;
  logic [lpud_pkg::ByteBits-1:0]     out_data;
  lpud_pkg::status_e                 status;
  logic                              first;
  logic                              last;

  // Classify the current byte and work out the next parser state
  always_comb begin
    frame_cur         = frame_start_i ? FrameLenBits'(frame_bytes_i) : frame_remaining_q;
    in_prefix_d       = frame_start_i ? 1'b1 : in_prefix_q;
    prefix_count_d    = frame_start_i ? 3'd0 : prefix_count_q;
    length_accum_d    = frame_start_i ? '0 : length_accum_q;
    unit_remaining_d  = frame_start_i ? '0 : unit_remaining_q;
    discarding_d      = frame_start_i ? 1'b0 : discarding_q;
    frame_remaining_d = frame_cur;
    frame_after       = frame_cur - 1'b1;
    cap               = (prefix_mode_i > 3'(lpud_pkg::MaxPrefix)) ?
                        3'(lpud_pkg::MaxPrefix) : prefix_mode_i;
    emit              = 1'b0;
    out_data          = '0;
    status            = lpud_pkg::StPayload;
    first             = 1'b0;
    last              = 1'b0;

    if (frame_cur != '0) begin
      if (discarding_d) begin
        // drop the rest of the frame
      end else if (!in_prefix_d) begin
        // payload byte inside a unit
        emit             = 1'b1;
        out_data         = data_byte_i;
        first            = (unit_remaining_d == length_accum_d);
        last             = (unit_remaining_d == LenW'(1));
        unit_remaining_d = unit_remaining_d - 1'b1;
        if (unit_remaining_d == '0) begin
          in_prefix_d    = 1'b1;
          prefix_count_d = '0;
          length_accum_d = '0;
        end
      end else if (prefix_count_d == '0 && prefix_mode_i > 3'(lpud_pkg::MaxPrefix)) begin
        discarding_d = 1'b1;
      end else if (prefix_count_d == '0 && prefix_mode_i == '0) begin
        // whole rest of the frame is one unit
        length_accum_d   = LenW'(frame_cur);
        unit_remaining_d = LenW'(frame_cur) - 1'b1;
        emit             = 1'b1;
        out_data         = data_byte_i;
        first            = 1'b1;
        last             = (unit_remaining_d == '0);
        if (unit_remaining_d == '0) begin
          length_accum_d = '0;
        end else begin
          in_prefix_d = 1'b0;
        end
      end else if (prefix_count_d == '0 && LenW'(frame_cur) <= LenW'(prefix_mode_i)) begin
        // prefix cannot complete before the frame ends
        discarding_d = 1'b1;
      end else begin
        // collect one little-endian prefix byte
        length_accum_d = length_accum_d |
                         (LenW'(data_byte_i) << {prefix_count_d[1:0], 3'b000});
        prefix_count_d = prefix_count_d + 1'b1;
        if (prefix_count_d >= cap) begin
          if (length_accum_d > LenW'(frame_after)) begin
            emit         = 1'b1;
            status       = lpud_pkg::StOverrun;
            first        = 1'b1;
            last         = 1'b1;
            discarding_d = 1'b1;
          end else if (length_accum_d == '0) begin
            emit           = 1'b1;
            status         = lpud_pkg::StEmpty;
            first          = 1'b1;
            last           = 1'b1;
            prefix_count_d = '0;
          end else begin
            in_prefix_d      = 1'b0;
            prefix_count_d   = '0;
            unit_remaining_d = length_accum_d;
          end
        end
      end

      // count down the frame and rearm at its end
      frame_remaining_d = frame_after;
      if (frame_after == '0) begin
        in_prefix_d      = 1'b1;
        prefix_count_d   = '0;
        length_accum_d   = '0;
        unit_remaining_d = '0;
        discarding_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_prefix_q       <= 1'b1;
      prefix_count_q    <= '0;
      length_accum_q    <= '0;
      unit_remaining_q  <= '0;
      frame_remaining_q <= '0;
      discarding_q      <= 1'b0;
    end else if (accept_i) begin
      in_prefix_q       <= in_prefix_d;
      prefix_count_q    <= prefix_count_d;
      length_accum_q    <= length_accum_d;
      unit_remaining_q  <= unit_remaining_d;
      frame_remaining_q <= frame_remaining_d;
      discarding_q      <= discarding_d;
    end
  end

  // Hand a record to the back for results and for frame starts
  assign rec_push_o     = accept_i && (emit || frame_start_i);
  assign rec_o.start    = frame_start_i;
  assign rec_o.emit     = emit;
  assign rec_o.kind     = frame_kind_i;
  assign rec_o.time_us  = time_us_i;
  assign rec_o.data     = out_data;
  assign rec_o.status   = status;
  assign rec_o.first    = first;
  assign rec_o.last     = last;

endmodule

### hw/rtl/lpud_back.sv
// Back end: converts the frame time to 90 kHz ticks and drives the result register.
module lpud_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rec_avail_i,
  input  lpud_pkg::rec_t                 rec_i,
  output logic                           rec_take_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [lpud_pkg::ByteBits-1:0]  unit_byte_o,
  output logic [1:0]                     status_o,
  output logic                           unit_first_o,
  output logic                           unit_last_o,
  output logic [lpud_pkg::KindBits-1:0]  out_kind_o,
  output logic [lpud_pkg::RtpBits-1:0]   rtp_time_o
);

  localparam int unsigned NStages = lpud_pkg::NDigits + 1;
  localparam int unsigned LastSt  = NStages - 1;
  localparam int unsigned WBits   = lpud_pkg::WBits;
  localparam int unsigned XBits   = lpud_pkg::XBits;
  localparam int unsigned RemBits = lpud_pkg::RemBits;
  localparam int unsigned ProdW   = XBits + lpud_pkg::RecipBits;
  localparam int unsigned BB      = lpud_pkg::ByteBits;
  localparam int unsigned RtpW    = lpud_pkg::RtpBits;

  logic                   vld_q  [NStages];
  lpud_pkg::rec_t         rec_q  [NStages];
  logic [WBits-1:0]       w_q    [NStages];
  logic [RemBits-1:0]     rem_q  [NStages];
  logic [RtpW-1:0]        quot_q [NStages];

  logic                          out_valid_q;
  logic [BB-1:0]                 out_byte_q;
  lpud_pkg::status_e             out_status_q;
  logic                          out_first_q, out_last_q;
  logic [lpud_pkg::KindBits-1:0] out_kind_q, held_kind_q, kind_now;
  logic [RtpW-1:0]               out_rtp_q, held_rtp_q, rtp_now;
  logic                          advance;
  logic [WBits-1:0]              w_in;

  // Move the whole pipeline unless a result waits untaken
  assign advance    = !out_valid_q || pop_i;
  assign rec_take_o = advance && rec_avail_i;

  // Scale and bias the time: t * 9 + 99
  assign w_in = (WBits'(rec_i.time_us) << 3) + WBits'(rec_i.time_us) +
                WBits'(lpud_pkg::RoundAdd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= rec_avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rec_q[0]  <= rec_i;
      w_q[0]    <= w_in;
      rem_q[0]  <= '0;
      quot_q[0] <= '0;
    end
  end

  // One base-256 digit of the division by 100 per stage, most significant first
  for (genvar i = 1; i < NStages; i++) begin : g_digit
    logic [XBits-1:0]   x;
    logic [ProdW-1:0]   prod;
    logic [BB-1:0]      qd;
    logic [XBits-1:0]   rem_full;

    assign x        = {rem_q[i-1], w_q[i-1][WBits-1-BB*(i-1) -: BB]};
    assign prod     = ProdW'(x) * ProdW'(lpud_pkg::DivRecip);
    assign qd       = BB'(prod >> lpud_pkg::DivShift);
    assign rem_full = x - XBits'(qd) * XBits'(lpud_pkg::DivBase);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (advance) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rec_q[i]  <= rec_q[i-1];
        w_q[i]    <= w_q[i-1];
        rem_q[i]  <= RemBits'(rem_full);
        quot_q[i] <= {quot_q[i-1][RtpW-BB-1:0], qd};
      end
    end
  end

  // A frame start brings its own kind and time
  assign kind_now = rec_q[LastSt].start ? rec_q[LastSt].kind : held_kind_q;
  assign rtp_now  = rec_q[LastSt].start ? quot_q[LastSt]     : held_rtp_q;

  // Hold the frame fields and load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_kind_q <= '0;
      held_rtp_q  <= '0;
    end else if (advance) begin
      out_valid_q <= vld_q[LastSt] && rec_q[LastSt].emit;
      if (vld_q[LastSt] && rec_q[LastSt].start) begin
        held_kind_q <= rec_q[LastSt].kind;
        held_rtp_q  <= quot_q[LastSt];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q   <= rec_q[LastSt].data;
      out_status_q <= rec_q[LastSt].status;
      out_first_q  <= rec_q[LastSt].first;
      out_last_q   <= rec_q[LastSt].last;
      out_kind_q   <= kind_now;
      out_rtp_q    <= rtp_now;
    end
  end

  assign empty_o      = !out_valid_q;
  assign unit_byte_o  = out_byte_q;
  assign status_o     = out_status_q;
  assign unit_first_o = out_first_q;
  assign unit_last_o  = out_last_q;
  assign out_kind_o   = out_kind_q;
  assign rtp_time_o   = out_rtp_q;

endmodule

### hw/rtl/length_prefixed_unit_deframer.sv
// Top level of the length-prefixed unit deframer.
//
// Takes one frame byte per push and splits the frame into units behind 0 to 4 byte
// little-endian length prefixes (prefix_mode), emitting one result per payload byte,
// an empty-unit marker for a zero length and an overrun error when a length runs past
// the frame end. The block takes one byte every cycle while full is low; full rises only
// when the four-beat record queue between the parser and the time converter backs up,
// which happens only while results are not popped. A result reaches the output ports
// once the byte that caused it has passed the record queue, whose read loads the scaled
// time, the digit-per-stage division by 100 that turns microseconds into 90 kHz ticks,
// and the result register; a result left untaken stalls the whole pipeline.
// No clearing pass follows reset. The configuration channel is always ready; write
// prefix_mode only while idle.
module length_prefixed_unit_deframer #(
  parameter int unsigned FrameLenBits = 24,
  parameter int unsigned FifoDepth    = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpud_pkg::ModeBits-1:0]  cfg_data_i,
  // input beats
  input  logic                           push,
  output logic                           full,
  input  logic [lpud_pkg::ByteBits-1:0]  data_byte_i,
  input  logic                           frame_start_i,
  input  logic [23:0]                    frame_bytes_i,
  input  logic [lpud_pkg::KindBits-1:0]  frame_kind_i,
  input  logic [lpud_pkg::TimeBits-1:0]  time_us_i,
  // result beats
  output logic                           empty,
  input  logic                           pop,
  output logic [lpud_pkg::ByteBits-1:0]  unit_byte_o,
  output logic [1:0]                     status_o,
  output logic                           unit_first_o,
  output logic                           unit_last_o,
  output logic [lpud_pkg::KindBits-1:0]  out_kind_o,
  output logic [lpud_pkg::RtpBits-1:0]   rtp_time_o
);

  logic [lpud_pkg::ModeBits-1:0] prefix_mode_q;
  logic                          accept;
  logic                          rec_push, rec_take, q_full, q_empty;
  lpud_pkg::rec_t                rec_wr, rec_rd;

  // Hold the prefix mode register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_mode_q <= lpud_pkg::ModeBits'(lpud_pkg::MaxPrefix);
    end else if (cfg_valid_i && cfg_ready_o) begin
      prefix_mode_q <= cfg_data_i;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  lpud_front #(
    .FrameLenBits(FrameLenBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .prefix_mode_i (prefix_mode_q),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .frame_bytes_i (frame_bytes_i),
    .frame_kind_i  (frame_kind_i),
    .time_us_i     (time_us_i),
    .rec_push_o    (rec_push),
    .rec_o         (rec_wr)
  );

  lpud_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rec_push),
    .wr_data_i (rec_wr),
    .rd_en_i   (rec_take),
    .rd_data_o (rec_rd),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  lpud_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_avail_i  (!q_empty),
    .rec_i        (rec_rd),
    .rec_take_o   (rec_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .unit_byte_o  (unit_byte_o),
    .status_o     (status_o),
    .unit_first_o (unit_first_o),
    .unit_last_o  (unit_last_o),
    .out_kind_o   (out_kind_o),
    .rtp_time_o   (rtp_time_o)
  );

endmodule
